// ===== hdl/vector3_normalize_defines.svh =====
// Assertion macros used by the vector normalizer RTL.
`ifndef VECTOR3_NORMALIZE_DEFINES_SVH
`define VECTOR3_NORMALIZE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define VN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/vn_pkg.sv =====
`timescale 1ns / 1ps
package vn_pkg;

  localparam int CompW   = 16;
  localparam int SumW    = 32;
  localparam int RootW   = 16;
  localparam int SqRemW  = 18;
  localparam int QuotW   = 15;
  localparam int DvRemW  = 17;
  localparam int Lanes   = 3;

  typedef struct packed {
    logic signed [CompW-1:0] in_x;
    logic signed [CompW-1:0] in_y;
    logic signed [CompW-1:0] in_z;
  } in_t;

  typedef struct packed {
    logic signed [CompW-1:0] unit_x;
    logic signed [CompW-1:0] unit_y;
    logic signed [CompW-1:0] unit_z;
    logic [CompW-1:0]        vec_length;
    logic                    is_zero;
  } out_t;

  typedef struct packed {
    logic [SumW-1:0]              n;
    logic [SqRemW-1:0]            rem;
    logic [RootW-1:0]             root;
    logic [Lanes-1:0]             neg;
    logic [Lanes-1:0][CompW-1:0]  mag;
  } sq_t;

  typedef struct packed {
    logic [RootW-1:0]              len;
    logic [Lanes-1:0]              neg;
    logic [Lanes-1:0][QuotW-1:0]   feed;
    logic [Lanes-1:0][DvRemW-1:0]  rem;
    logic [Lanes-1:0][QuotW-1:0]   q;
  } dv_t;

endpackage

// ===== hdl/vector3_normalize.sv =====
// vector3_normalize: unit vector and length of a signed Q8.8 3-vector.
// Input: drive in_data and raise start; the item is taken at any edge with
// start high and busy low. busy stays low, so one item can enter per cycle.
// Output: out_valid pulses for one cycle with out_data holding unit_x/y/z
// (signed Q1.14), vec_length (unsigned Q8.8, floored) and is_zero.
// The pipeline holds one magnitude stage, one squaring stage, one sum stage,
// 16 square-root digit cells, 15 divider cells (three lanes each) and the
// output register. Throughput is one item per cycle; the cell chain sets it.
// Results come in input order. The receiver cannot stall; each result must
// be taken in the cycle it appears.
// Reset (rst_n low, synchronous) clears every valid bit, dropping items in
// flight; payload registers are not reset.
`timescale 1ns / 1ps
module vector3_normalize (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  vn_pkg::in_t   in_data,
  output logic          out_valid,
  output vn_pkg::out_t  out_data
);
  import vn_pkg::*;
  `include "vector3_normalize_defines.svh"

  localparam int SqCells = RootW;
  localparam int DvCells = QuotW;

  logic [Lanes-1:0][CompW-1:0] comp;
  logic                        acc;

  logic                        m_v_r;
  logic [Lanes-1:0][CompW-1:0] mag_r;
  logic [Lanes-1:0]            neg_r;
  logic                        s_v_r;
  logic [Lanes-1:0][SumW-1:0]  sq_r;
  logic [Lanes-1:0][CompW-1:0] mag2_r;
  logic [Lanes-1:0]            neg2_r;
  logic                        a_v_r;
  logic [SumW-1:0]             sum_r;
  logic [Lanes-1:0][CompW-1:0] mag3_r;
  logic [Lanes-1:0]            neg3_r;

  logic [SqCells:0] sv;
  sq_t  [SqCells:0] sd;
  logic [DvCells:0] dvv;
  dv_t  [DvCells:0] dd;

  logic [Lanes-1:0][CompW-1:0] unit;
  out_t                        out_nxt;
  out_t                        out_r;
  logic                        out_v_r;

  assign busy = 1'b0;
  assign acc  = start && !busy;
  assign comp = {in_data.in_z, in_data.in_y, in_data.in_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r   <= 1'b0;
      s_v_r   <= 1'b0;
      a_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      m_v_r   <= acc;
      s_v_r   <= m_v_r;
      a_v_r   <= s_v_r;
      out_v_r <= dvv[DvCells];
    end
    for (int i = 0; i < Lanes; i++) begin
      neg_r[i] <= comp[i][CompW-1];
      mag_r[i] <= comp[i][CompW-1] ? (~comp[i] + 1'b1) : comp[i];
      sq_r[i]  <= mag_r[i] * mag_r[i];
    end
    mag2_r <= mag_r;
    neg2_r <= neg_r;
    sum_r  <= sq_r[0] + sq_r[1] + sq_r[2];
    mag3_r <= mag2_r;
    neg3_r <= neg2_r;
    out_r  <= out_nxt;
  end

  assign sv[0]      = a_v_r;
  assign sd[0].n    = sum_r;
  assign sd[0].rem  = '0;
  assign sd[0].root = '0;
  assign sd[0].neg  = neg3_r;
  assign sd[0].mag  = mag3_r;

  for (genvar g = 0; g < SqCells; g++) begin : g_sq
    vn_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .v_i   (sv[g]),
      .d_i   (sd[g]),
      .v_o   (sv[g+1]),
      .d_o   (sd[g+1])
    );
  end

  assign dvv[0]    = sv[SqCells];
  assign dd[0].len = sd[SqCells].root;
  assign dd[0].neg = sd[SqCells].neg;

  for (genvar i = 0; i < Lanes; i++) begin : g_lane
    assign dd[0].rem[i]  = {2'b00, sd[SqCells].mag[i][CompW-1:1]};
    assign dd[0].feed[i] = {sd[SqCells].mag[i][0], {(QuotW-1){1'b0}}};
    assign dd[0].q[i]    = '0;
  end

  for (genvar g = 0; g < DvCells; g++) begin : g_dv
    vn_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .v_i   (dvv[g]),
      .d_i   (dd[g]),
      .v_o   (dvv[g+1]),
      .d_o   (dd[g+1])
    );
  end

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      unit[i] = dd[DvCells].neg[i] ? (~{1'b0, dd[DvCells].q[i]} + 1'b1)
                                   : {1'b0, dd[DvCells].q[i]};
    end
    if (dd[DvCells].len == '0) begin
      out_nxt = '0;
      out_nxt.is_zero = 1'b1;
    end else begin
      out_nxt.unit_x     = unit[0];
      out_nxt.unit_y     = unit[1];
      out_nxt.unit_z     = unit[2];
      out_nxt.vec_length = dd[DvCells].len;
      out_nxt.is_zero    = 1'b0;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `VN_ASSERT_IMP(a_busy_low, 1'b1, !busy, "busy raised")
  `VN_ASSERT_IMP(a_zero_fields, out_valid && out_data.is_zero, out_data.unit_x == '0 && out_data.unit_y == '0 && out_data.unit_z == '0 && out_data.vec_length == '0, "zero item with nonzero fields")
  `VN_ASSERT_IMP(a_len_nonzero, out_valid && !out_data.is_zero, out_data.vec_length != '0, "nonzero item with zero length")
  `VN_ASSERT_IMP(a_unit_range, out_valid, out_data.unit_x >= -16'sd16384 && out_data.unit_x <= 16'sd16384, "unit_x out of range")
  `VN_ASSERT_NXT(a_sum_flow, s_v_r, a_v_r, "sum stage dropped an item")

endmodule

// ===== hdl/vn_sqrt_cell.sv =====
`timescale 1ns / 1ps
module vn_sqrt_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         v_i,
  input  vn_pkg::sq_t  d_i,
  output logic         v_o,
  output vn_pkg::sq_t  d_o
);
  import vn_pkg::*;

  logic [SqRemW-1:0] r2;
  logic [SqRemW-1:0] trial;
  sq_t               d_nxt;
  logic              v_r;
  sq_t               d_r;

  always_comb begin
    r2    = {d_i.rem[SqRemW-3:0], d_i.n[SumW-1 -: 2]};
    trial = {d_i.root, 2'b01};
    d_nxt = d_i;
    d_nxt.n = {d_i.n[SumW-3:0], 2'b00};
    if (r2 >= trial) begin
      d_nxt.rem  = r2 - trial;
      d_nxt.root = {d_i.root[RootW-2:0], 1'b1};
    end else begin
      d_nxt.rem  = r2;
      d_nxt.root = {d_i.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_i;
    end
    d_r <= d_nxt;
  end

  assign v_o = v_r;
  assign d_o = d_r;

endmodule

// ===== hdl/vn_div_cell.sv =====
`timescale 1ns / 1ps
module vn_div_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         v_i,
  input  vn_pkg::dv_t  d_i,
  output logic         v_o,
  output vn_pkg::dv_t  d_o
);
  import vn_pkg::*;

  logic [Lanes-1:0][DvRemW-1:0] r2;
  dv_t                          d_nxt;
  logic                         v_r;
  dv_t                          d_r;

  always_comb begin
    d_nxt = d_i;
    for (int i = 0; i < Lanes; i++) begin
      r2[i] = {d_i.rem[i][DvRemW-2:0], d_i.feed[i][QuotW-1]};
      d_nxt.feed[i] = {d_i.feed[i][QuotW-2:0], 1'b0};
      if (r2[i] >= {1'b0, d_i.len}) begin
        d_nxt.rem[i] = r2[i] - {1'b0, d_i.len};
        d_nxt.q[i]   = {d_i.q[i][QuotW-2:0], 1'b1};
      end else begin
        d_nxt.rem[i] = r2[i];
        d_nxt.q[i]   = {d_i.q[i][QuotW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_i;
    end
    d_r <= d_nxt;
  end

  assign v_o = v_r;
  assign d_o = d_r;

endmodule
